[hdl/chi_pkg.sv]
// Shared types, microcode words and the control program of the hash table sequencer.
package chi_pkg;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_MUL  = 3'd1;
	localparam step_t STEP_MOD  = 3'd2;
	localparam step_t STEP_FRD  = 3'd3;
	localparam step_t STEP_FDAT = 3'd4;
	localparam step_t STEP_SRD  = 3'd5;
	localparam step_t STEP_CMP  = 3'd6;
	localparam step_t STEP_ANS  = 3'd7;

	typedef logic [2:0] cond_t;

	localparam cond_t COND_NEVER   = 3'd0;
	localparam cond_t COND_ACCEPT  = 3'd1;
	localparam cond_t COND_INSERT  = 3'd2;
	localparam cond_t COND_SZERO   = 3'd3;
	localparam cond_t COND_DONE    = 3'd4;
	localparam cond_t COND_OUTFREE = 3'd5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// datapath strobes of one control word
	typedef struct packed {
		logic ready;
		logic mul;
		logic hmod;
		logic frd;
		logic fdat;
		logic srd;
		logic cmp;
		logic ans;
	} ctrl_t;

	// conditions seen by the sequencer
	typedef struct packed {
		logic accept;
		logic insert;
		logic s_zero;
		logic done;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic       insert;
		logic       s_zero;
		logic       done;
	} dp_flags_t;

	typedef struct packed {
		logic       found;
		logic [3:0] probes;
		logic [2:0] bucket;
		logic       overflow;
	} res_t;

	typedef struct packed {
		ctrl_t ctrl;
		cond_t cond;
		step_t target;
		step_t next;
	} uword_t;

	localparam ctrl_t CTRL_NONE = '{default: 1'b0};

	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		w = '{ctrl: CTRL_NONE, cond: COND_NEVER, target: STEP_IDLE, next: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				w.ctrl.ready = 1'b1;
				w.cond = COND_ACCEPT;
				w.target = STEP_MUL;
				w.next = STEP_IDLE;
			end
			STEP_MUL: begin
				w.ctrl.mul = 1'b1;
				w.next = STEP_MOD;
			end
			STEP_MOD: begin
				w.ctrl.hmod = 1'b1;
				w.next = STEP_FRD;
			end
			STEP_FRD: begin
				w.ctrl.frd = 1'b1;
				w.next = STEP_FDAT;
			end
			STEP_FDAT: begin
				w.ctrl.fdat = 1'b1;
				w.cond = COND_INSERT;
				w.target = STEP_ANS;
				w.next = STEP_SRD;
			end
			STEP_SRD: begin
				w.ctrl.srd = 1'b1;
				w.cond = COND_SZERO;
				w.target = STEP_ANS;
				w.next = STEP_CMP;
			end
			STEP_CMP: begin
				w.ctrl.cmp = 1'b1;
				w.cond = COND_DONE;
				w.target = STEP_ANS;
				w.next = STEP_CMP;
			end
			STEP_ANS: begin
				w.ctrl.ans = 1'b1;
				w.cond = COND_OUTFREE;
				w.target = STEP_IDLE;
				w.next = STEP_ANS;
			end
			default: begin
				w.next = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[hdl/chi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module chi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hdl/chi_useq.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
module chi_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  chi_pkg::stat_t   stat,
	output chi_pkg::ctrl_t   ctrl
);

	chi_pkg::step_t  step_q;
	chi_pkg::step_t  step_d;
	chi_pkg::uword_t uw;
	logic            take;

	always_comb begin
		uw = chi_pkg::ucode_rom(step_q);
		unique case (uw.cond)
			chi_pkg::COND_NEVER:   take = 1'b0;
			chi_pkg::COND_ACCEPT:  take = stat.accept;
			chi_pkg::COND_INSERT:  take = stat.insert;
			chi_pkg::COND_SZERO:   take = stat.s_zero;
			chi_pkg::COND_DONE:    take = stat.done;
			chi_pkg::COND_OUTFREE: take = stat.out_free;
			default:               take = 1'b0;
		endcase
		step_d = take ? uw.target : uw.next;
		ctrl = uw.ctrl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= chi_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[hdl/chi_dpath.sv]
// Datapath: modulo hash, fill counters, slot store and key compare.
module chi_dpath #(
	parameter int BUCKETS  = 8,
	parameter int SLOTS    = 8,
	parameter int KEY_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  chi_pkg::ctrl_t      ctrl,
	input  logic                load,
	input  logic                cmd,
	input  logic [15:0]         key,
	output chi_pkg::dp_flags_t  flags,
	output chi_pkg::res_t       res
);

	localparam int KW    = (KEY_BITS < 16) ? KEY_BITS : 16;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW    = $clog2(SLOTS + 1);
	localparam int DEPTH = BUCKETS * SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / BUCKETS + 1);

	logic          cmd_q;
	logic [KW-1:0] key_q;
	logic [15:0]   q_q;
	logic [BW-1:0] r_q;
	logic [AW-1:0] base_q;
	logic [FW-1:0] s_q;
	logic [FW-1:0] probes_q;
	logic          found_q;
	logic          ovf_q;
	logic          fvalid_q;
	logic [BUCKETS-1:0] fill_vld_q;

	logic [15:0]   key16;
	logic [48:0]   prod;
	logic [22:0]   qb;
	logic [22:0]   rem;
	logic [FW-1:0] fill_rdata;
	logic [FW-1:0] fill;
	logic          full;
	logic          ins_wr;
	logic [KW-1:0] slot_rdata;
	logic          match;
	logic          s_zero;
	logic          done;
	logic          slot_rd;
	logic [AW-1:0] slot_raddr;
	logic [FW+3:0] probes_ext;
	logic [BW+2:0] bucket_ext;

	always_comb begin
		key16  = 16'(key_q);
		prod   = key16 * RECIP;
		qb     = q_q * 23'(BUCKETS);
		rem    = 23'(key16) - qb;
		fill   = fvalid_q ? fill_rdata : '0;
		full   = (fill >= FW'(SLOTS));
		ins_wr = ctrl.fdat && (cmd_q == chi_pkg::CMD_INSERT) && !full;
		match  = (slot_rdata == key_q);
		s_zero = (s_q == '0);
		done   = match || s_zero;
		slot_rd = !s_zero && (ctrl.srd || (ctrl.cmp && !done));
		slot_raddr = base_q + AW'(s_q - FW'(1));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
			key_q <= key[KW-1:0];
		end
		if (ctrl.mul) begin
			q_q <= prod[47:32];
		end
		if (ctrl.hmod) begin
			r_q <= rem[BW-1:0];
		end
		if (ctrl.frd) begin
			fvalid_q <= fill_vld_q[r_q];
			base_q   <= AW'(r_q) * AW'(SLOTS);
		end
		if (ctrl.fdat) begin
			s_q      <= fill;
			probes_q <= '0;
			found_q  <= 1'b0;
			ovf_q    <= (cmd_q == chi_pkg::CMD_INSERT) && full;
		end
		if (slot_rd) begin
			s_q <= s_q - FW'(1);
		end
		if (ctrl.cmp) begin
			probes_q <= probes_q + FW'(1);
			found_q  <= match;
		end
	end

	// mark a bucket's count as written; unmarked buckets read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
		end else if (ins_wr) begin
			fill_vld_q[r_q] <= 1'b1;
		end
	end

	chi_ram #(
		.WIDTH(FW),
		.DEPTH(BUCKETS)
	) u_fill_ram (
		.clk     (clk),
		.wr_en   (ins_wr),
		.wr_addr (r_q),
		.wr_data (FW'(fill + FW'(1))),
		.rd_en   (ctrl.frd),
		.rd_addr (r_q),
		.rd_data (fill_rdata)
	);

	chi_ram #(
		.WIDTH(KW),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ins_wr),
		.wr_addr (AW'(base_q + AW'(fill))),
		.wr_data (key_q),
		.rd_en   (slot_rd),
		.rd_addr (slot_raddr),
		.rd_data (slot_rdata)
	);

	always_comb begin
		probes_ext   = (FW + 4)'(probes_q);
		bucket_ext   = (BW + 3)'(r_q);
		flags.insert = (cmd_q == chi_pkg::CMD_INSERT);
		flags.s_zero = s_zero;
		flags.done   = done;
		res.found    = found_q;
		res.probes   = probes_ext[3:0];
		res.bucket   = bucket_ext[2:0];
		res.overflow = ovf_q;
	end

endmodule

[hdl/chained_hash_insert_search_top.sv]
// Top level of the chained hash table: stream ports, sequencer, datapath, result register.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | tuser: command (0 insert, 1 search); tdata: key
//  m_*      | out       | tdata: found, probes, bucket, overflow
//
// An insert passes the multiply, modulo, fill read, fill data and answer
// steps; a search adds a slot read step and a compare step per probe.
// The slot store has one read port, so a search compares one stored key
// per cycle, newest first. Reset clears the step counter, the result
// valid flag and the per-bucket valid bits; bucket counts not yet written
// read as zero, so no clearing pass is needed. A stalled result holds in
// the output register while the sequencer waits in its answer step.
module chained_hash_insert_search_top #(
	parameter int BUCKETS  = 8,
	parameter int SLOTS    = 8,
	parameter int KEY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] key
	input  logic [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] found, [4:1] probes, [7:5] bucket, [8] overflow
);

	chi_pkg::ctrl_t     ctrl;
	chi_pkg::stat_t     stat;
	chi_pkg::dp_flags_t flags;
	chi_pkg::res_t      res;

	logic        accept;
	logic        out_free;
	logic        out_load;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	// take a request only in the idle step of the program, never in reset
	assign s_tready = ctrl.ready && arst_n;
	assign accept   = s_tvalid && s_tready;

	// the answer step may load the result register once it is empty or draining
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = ctrl.ans && out_free;

	always_comb begin
		stat.accept   = accept;
		stat.insert   = flags.insert;
		stat.s_zero   = flags.s_zero;
		stat.done     = flags.done;
		stat.out_free = out_free;
	end

	chi_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	chi_dpath #(
		.BUCKETS  (BUCKETS),
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.load   (accept),
		.cmd    (s_tuser[0]),
		.key    (s_tdata),
		.flags  (flags),
		.res    (res)
	);

	// result register: hold until taken, advance on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {7'd0, res.overflow, res.bucket, res.probes, res.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a taken request always makes the input port busy before the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken on consecutive cycles");

	// a result never reports both a hit and a dropped insert
	a_found_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[8]))
		else $error("found and overflow both set");

	// dropped inserts make no comparisons
	a_ovf_no_probes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> (m_tdata[4:1] == 4'd0))
		else $error("overflow result with nonzero probes");

	// probe count never exceeds the bucket depth
	a_probes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((SLOTS > 15) || (int'(m_tdata[4:1]) <= SLOTS)))
		else $error("probe count above slot count");

endmodule
